// ----- src/bmhq_pkg.sv -----
// Package for the binary min-heap priority queue.
// Holds sizes, request and result structs, memory port struct and FSM states.
// No dependencies.
package bmhq_pkg;

	localparam int HEAP_DEPTH = 1024;
	localparam int KEY_BITS   = 16;
	localparam int PRIO_BITS  = 32;
	localparam int ADDR_W     = $clog2(HEAP_DEPTH);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int ENTRY_W    = KEY_BITS + PRIO_BITS;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]  key;
		logic [PRIO_BITS-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic [1:0]           req_type;
		logic [KEY_BITS-1:0]  key;
		logic [PRIO_BITS-1:0] priority_req;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic                 top_valid;
		logic [KEY_BITS-1:0]  top_key;
		logic [PRIO_BITS-1:0] top_priority;
		logic [CNT_W-1:0]     entry_total;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_CMP,
		S_UP_PUT,
		S_POP_LAST,
		S_DN_STEP,
		S_DN_READR,
		S_DN_CMP,
		S_RESP
	} state_t;

endpackage

// ----- src/bmhq_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module bmhq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/bmhq_sift.sv -----
// Heap sequencer: entry count, sift-up and sift-down over the entry memory.
// Depends on bmhq_pkg; drives the RAM through a bmhq_pkg::mem_req_t.
module bmhq_sift (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  bmhq_pkg::req_t             req,
	input  bmhq_pkg::entry_t           rd_data,
	output logic                       busy,
	output logic                       done,
	output bmhq_pkg::status_t          status,
	output logic [bmhq_pkg::CNT_W-1:0] count,
	output bmhq_pkg::mem_req_t         mem
);

	bmhq_pkg::state_t  state_q, state_d;
	bmhq_pkg::status_t status_q;
	logic [bmhq_pkg::CNT_W-1:0]  count_q;
	logic [bmhq_pkg::ADDR_W-1:0] pos_q;
	bmhq_pkg::entry_t            cur_q, left_q;
	logic                        right_q;

	logic accept, is_push, is_pop, full;
	logic [bmhq_pkg::ADDR_W-1:0] push_pos, push_parent, last_addr, parent, grand;
	logic [bmhq_pkg::CNT_W:0]    n_ext, left_idx, right_idx, new_left;
	logic has_left, has_right, new_has_left, up_swap, dn_swap, take_right;
	bmhq_pkg::entry_t            child;
	logic [bmhq_pkg::ADDR_W-1:0] csel;
	bmhq_pkg::entry_t            push_entry;

	assign accept      = start && (state_q == bmhq_pkg::S_IDLE);
	assign is_push     = req.req_type == bmhq_pkg::OP_PUSH;
	assign is_pop      = req.req_type == bmhq_pkg::OP_POP;
	assign full        = count_q == bmhq_pkg::CNT_W'(bmhq_pkg::HEAP_DEPTH);
	assign push_pos    = count_q[bmhq_pkg::ADDR_W-1:0];
	assign push_parent = (push_pos - 1'b1) >> 1;
	assign last_addr   = bmhq_pkg::ADDR_W'(count_q - 1'b1);
	assign parent      = (pos_q - 1'b1) >> 1;
	assign grand       = (parent - 1'b1) >> 1;
	assign push_entry.key  = req.key[bmhq_pkg::KEY_BITS-1:0];
	assign push_entry.prio = req.priority_req;

	assign n_ext     = {1'b0, count_q};
	assign left_idx  = {1'b0, pos_q, 1'b1};
	assign right_idx = left_idx + 1'b1;
	assign has_left  = left_idx < n_ext;
	assign has_right = right_idx < n_ext;

	assign up_swap    = rd_data.prio > cur_q.prio;
	assign take_right = right_q && (rd_data.prio < left_q.prio);
	assign child      = take_right ? rd_data : left_q;
	assign csel       = take_right ? right_idx[bmhq_pkg::ADDR_W-1:0]
	                               : left_idx[bmhq_pkg::ADDR_W-1:0];
	assign dn_swap      = cur_q.prio > child.prio;
	assign new_left     = {1'b0, csel, 1'b1};
	assign new_has_left = new_left < n_ext;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bmhq_pkg::S_IDLE: begin
				if (start) begin
					if (is_push && !full) begin
						state_d = (count_q == '0) ? bmhq_pkg::S_UP_PUT : bmhq_pkg::S_UP_CMP;
					end else if (is_pop && count_q > bmhq_pkg::CNT_W'(1)) begin
						state_d = bmhq_pkg::S_POP_LAST;
					end else begin
						state_d = bmhq_pkg::S_RESP;
					end
				end
			end
			bmhq_pkg::S_UP_CMP: begin
				if (!up_swap) begin
					state_d = bmhq_pkg::S_RESP;
				end else if (parent == '0) begin
					state_d = bmhq_pkg::S_UP_PUT;
				end
			end
			bmhq_pkg::S_UP_PUT:   state_d = bmhq_pkg::S_RESP;
			bmhq_pkg::S_POP_LAST: state_d = bmhq_pkg::S_DN_STEP;
			bmhq_pkg::S_DN_STEP: begin
				state_d = has_left ? bmhq_pkg::S_DN_READR : bmhq_pkg::S_RESP;
			end
			bmhq_pkg::S_DN_READR: state_d = bmhq_pkg::S_DN_CMP;
			bmhq_pkg::S_DN_CMP: begin
				if (!dn_swap) begin
					state_d = bmhq_pkg::S_RESP;
				end else begin
					state_d = new_has_left ? bmhq_pkg::S_DN_READR : bmhq_pkg::S_DN_STEP;
				end
			end
			bmhq_pkg::S_RESP: state_d = bmhq_pkg::S_IDLE;
			default:          state_d = bmhq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mem   = '0;
		busy  = state_q != bmhq_pkg::S_IDLE;
		done  = state_q == bmhq_pkg::S_RESP;
		case (state_q)
			bmhq_pkg::S_IDLE: begin
				if (start && is_push && !full && count_q != '0) begin
					mem.re    = 1'b1;
					mem.raddr = push_parent;
				end else if (start && is_pop && count_q > bmhq_pkg::CNT_W'(1)) begin
					mem.re    = 1'b1;
					mem.raddr = last_addr;
				end
			end
			bmhq_pkg::S_UP_CMP: begin
				mem.we    = 1'b1;
				mem.waddr = pos_q;
				if (up_swap) begin
					mem.wdata = rd_data;
					mem.re    = parent != '0;
					mem.raddr = grand;
				end else begin
					mem.wdata = cur_q;
				end
			end
			bmhq_pkg::S_UP_PUT: begin
				mem.we    = 1'b1;
				mem.waddr = pos_q;
				mem.wdata = cur_q;
			end
			bmhq_pkg::S_DN_STEP: begin
				if (has_left) begin
					mem.re    = 1'b1;
					mem.raddr = left_idx[bmhq_pkg::ADDR_W-1:0];
				end else begin
					mem.we    = 1'b1;
					mem.waddr = pos_q;
					mem.wdata = cur_q;
				end
			end
			bmhq_pkg::S_DN_READR: begin
				mem.re    = has_right;
				mem.raddr = right_idx[bmhq_pkg::ADDR_W-1:0];
			end
			bmhq_pkg::S_DN_CMP: begin
				mem.we    = 1'b1;
				mem.waddr = pos_q;
				if (dn_swap) begin
					mem.wdata = child;
					mem.re    = new_has_left;
					mem.raddr = new_left[bmhq_pkg::ADDR_W-1:0];
				end else begin
					mem.wdata = cur_q;
				end
			end
			default: begin
				mem = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bmhq_pkg::S_IDLE;
			status_q <= bmhq_pkg::ST_DONE;
			count_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				status_q <= bmhq_pkg::ST_DONE;
				if (is_push) begin
					if (full) begin
						status_q <= bmhq_pkg::ST_FULL;
					end else begin
						count_q <= count_q + 1'b1;
					end
				end else if (is_pop) begin
					if (count_q == '0) begin
						status_q <= bmhq_pkg::ST_EMPTY;
					end else begin
						count_q <= count_q - 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bmhq_pkg::S_IDLE: begin
				cur_q <= push_entry;
				pos_q <= push_pos;
			end
			bmhq_pkg::S_UP_CMP: begin
				if (up_swap) begin
					pos_q <= parent;
				end
			end
			bmhq_pkg::S_POP_LAST: begin
				cur_q <= rd_data;
				pos_q <= '0;
			end
			bmhq_pkg::S_DN_READR: begin
				left_q  <= rd_data;
				right_q <= has_right;
			end
			bmhq_pkg::S_DN_CMP: begin
				if (dn_swap) begin
					pos_q <= csel;
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign status = status_q;
	assign count  = count_q;

endmodule

// ----- src/binary_min_heap_queue_unit.sv -----
// Top level of the binary min-heap priority queue.
// Depends on bmhq_pkg, bmhq_ram and bmhq_sift.
//
// A request is taken at a rising edge with start high and busy low. The request
// carries req_type (push, pop minimum, query), key and priority_req, where the
// priority is unsigned 16.16 fixed point and only compared. Every request gives
// exactly one result on rsp, marked by done for one cycle: status, the root
// entry after the operation (zero when the heap is empty) and the entry count.
// The receiver cannot hold results off, and busy stays high through the done cycle.
// A query, a refused request or a pop of the only entry goes straight to the
// done state. A push compares the new entry with its parent at each level that
// it climbs and writes it where it stops. A pop moves the last entry to the root
// and sinks it, reading the children one after the other through the single read
// port of the entry memory. Reset clears the count to zero; the entry memory
// needs no clearing because only entries below the count are ever read. The root
// entry is mirrored in registers so results never wait for a read.
module binary_min_heap_queue_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bmhq_pkg::req_t   req,
	output logic             busy,
	output logic             done,
	output bmhq_pkg::rsp_t   rsp
);

	bmhq_pkg::mem_req_t          mem;
	bmhq_pkg::entry_t            rd_data;
	bmhq_pkg::status_t           status;
	logic [bmhq_pkg::CNT_W-1:0]  count;
	logic [bmhq_pkg::ENTRY_W-1:0] rd_bits;
	bmhq_pkg::entry_t            root_q;
	logic                        nonempty;

	bmhq_sift u_sift (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.rd_data (rd_data),
		.busy    (busy),
		.done    (done),
		.status  (status),
		.count   (count),
		.mem     (mem)
	);

	bmhq_ram #(
		.WIDTH (bmhq_pkg::ENTRY_W),
		.DEPTH (bmhq_pkg::HEAP_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (rd_bits)
	);

	assign rd_data = rd_bits;

	always_ff @(posedge clk) begin
		if (mem.we && mem.waddr == '0) begin
			root_q <= mem.wdata;
		end
	end

	assign nonempty = count != '0;

	always_comb begin
		rsp.status       = status;
		rsp.top_valid    = nonempty;
		rsp.top_key      = nonempty ? root_q.key : '0;
		rsp.top_priority = nonempty ? root_q.prio : '0;
		rsp.entry_total  = count;
	end

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for binary_min_heap_queue_unit, the min-heap priority queue.
// Requests go in through start and busy; each done strobe is checked against a model heap.
// Depends on bmhq_pkg and the RTL of the queue.
module tb_top;

	localparam logic [1:0] OP_QUERY  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		bmhq_pkg::req_t rq;
		bit             typed;
		bmhq_pkg::rsp_t want;
	} stim_row_t;

	logic           clk;
	logic           arst_n;
	logic           start;
	bmhq_pkg::req_t req;
	logic           busy;
	logic           done;
	bmhq_pkg::rsp_t rsp;

	logic [bmhq_pkg::KEY_BITS-1:0]  heap_key [bmhq_pkg::HEAP_DEPTH];
	logic [bmhq_pkg::PRIO_BITS-1:0] heap_prio [bmhq_pkg::HEAP_DEPTH];
	int unsigned                    heap_count;
	bmhq_pkg::rsp_t                 pending_rsp [$];
	int unsigned                    mismatch_count;
	stim_row_t                      directed_rows [$];
	bit                             no_idle;

	binary_min_heap_queue_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb_top failed");
		$finish;
	end

	function automatic bmhq_pkg::req_t req_of(input logic [1:0] op,
			input logic [bmhq_pkg::KEY_BITS-1:0] k, input logic [bmhq_pkg::PRIO_BITS-1:0] p);
		bmhq_pkg::req_t r;
		r.req_type = op;
		r.key = k;
		r.priority_req = p;
		return r;
	endfunction

	function automatic bmhq_pkg::rsp_t rsp_of(input bmhq_pkg::status_t s, input logic v,
			input logic [bmhq_pkg::KEY_BITS-1:0] k, input logic [bmhq_pkg::PRIO_BITS-1:0] p,
			input int unsigned n);
		bmhq_pkg::rsp_t r;
		r.status = s;
		r.top_valid = v;
		r.top_key = k;
		r.top_priority = p;
		r.entry_total = bmhq_pkg::CNT_W'(n);
		return r;
	endfunction

	function automatic void swap_entries(input int unsigned a, input int unsigned b);
		logic [bmhq_pkg::KEY_BITS-1:0]  tk;
		logic [bmhq_pkg::PRIO_BITS-1:0] tp;
		tk = heap_key[a];
		tp = heap_prio[a];
		heap_key[a] = heap_key[b];
		heap_prio[a] = heap_prio[b];
		heap_key[b] = tk;
		heap_prio[b] = tp;
	endfunction

	function automatic bmhq_pkg::rsp_t apply_request(input bmhq_pkg::req_t r);
		bmhq_pkg::rsp_t res;
		int unsigned    pos;
		int unsigned    child;
		bit             moving;
		res = '0;
		res.status = bmhq_pkg::ST_DONE;
		case (r.req_type)
		bmhq_pkg::OP_PUSH: begin
			if (heap_count >= bmhq_pkg::HEAP_DEPTH) begin
				res.status = bmhq_pkg::ST_FULL;
			end else begin
				heap_key[heap_count] = r.key;
				heap_prio[heap_count] = r.priority_req;
				pos = heap_count;
				heap_count++;
				while (pos > 0 && heap_prio[(pos - 1) / 2] > heap_prio[pos]) begin
					swap_entries((pos - 1) / 2, pos);
					pos = (pos - 1) / 2;
				end
			end
		end
		bmhq_pkg::OP_POP: begin
			if (heap_count == 0) begin
				res.status = bmhq_pkg::ST_EMPTY;
			end else begin
				heap_key[0] = heap_key[heap_count - 1];
				heap_prio[0] = heap_prio[heap_count - 1];
				heap_count--;
				pos = 0;
				moving = 1'b1;
				while (moving && 2 * pos + 1 < heap_count) begin
					child = 2 * pos + 1;
					if (child + 1 < heap_count && heap_prio[child + 1] < heap_prio[child])
						child++;
					if (heap_prio[pos] > heap_prio[child]) begin
						swap_entries(pos, child);
						pos = child;
					end else begin
						moving = 1'b0;
					end
				end
			end
		end
		default: begin
		end
		endcase
		if (heap_count > 0) begin
			res.top_valid = 1'b1;
			res.top_key = heap_key[0];
			res.top_priority = heap_prio[0];
		end
		res.entry_total = bmhq_pkg::CNT_W'(heap_count);
		return res;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	// Drives one request after the given number of idle cycles and records the
	// expected result once the request has been accepted.
	task automatic drive_request(input bmhq_pkg::req_t r, input int unsigned gap,
			input bit typed, input bmhq_pkg::rsp_t want);
		bmhq_pkg::rsp_t predicted;
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = apply_request(r);
		pending_rsp.push_back(typed ? want : predicted);
	endtask

	function automatic logic [bmhq_pkg::PRIO_BITS-1:0] draw_priority();
		case ($urandom_range(0, 3))
		0: return bmhq_pkg::PRIO_BITS'($urandom_range(0, 7));
		1: return {16'($urandom_range(0, 3)), 16'h0000};
		2: return $urandom;
		default: return $urandom_range(0, 1) ? '1 : '0;
		endcase
	endfunction

	function automatic logic [1:0] pick_op(input int unsigned push_weight);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < push_weight)
			return bmhq_pkg::OP_PUSH;
		if (roll < 90)
			return bmhq_pkg::OP_POP;
		if (roll < 96)
			return OP_QUERY;
		return OP_UNUSED;
	endfunction

	task automatic drive_random(input logic [1:0] op);
		drive_request(req_of(op, bmhq_pkg::KEY_BITS'($urandom), draw_priority()),
			no_idle ? 0 : $urandom_range(0, 5), 1'b0, '0);
	endtask

	always @(posedge clk) begin
		bmhq_pkg::rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				flag_mismatch("result with no request outstanding");
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status)
					flag_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
				if (rsp.top_valid !== want.top_valid)
					flag_mismatch($sformatf("top_valid %0b, expected %0b",
						rsp.top_valid, want.top_valid));
				if (rsp.top_key !== want.top_key)
					flag_mismatch($sformatf("top_key %h, expected %h", rsp.top_key, want.top_key));
				if (rsp.top_priority !== want.top_priority)
					flag_mismatch($sformatf("top_priority %h, expected %h",
						rsp.top_priority, want.top_priority));
				if (rsp.entry_total !== want.entry_total)
					flag_mismatch($sformatf("entry_total %0d, expected %0d",
						rsp.entry_total, want.entry_total));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		heap_count = 0;
		mismatch_count = 0;
		no_idle = 1'b0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_rows.push_back('{req_of(OP_QUERY, '0, '0), 1'b1,
			rsp_of(bmhq_pkg::ST_DONE, 1'b0, '0, '0, 0)});
		directed_rows.push_back('{req_of(bmhq_pkg::OP_POP, '1, '1), 1'b1,
			rsp_of(bmhq_pkg::ST_EMPTY, 1'b0, '0, '0, 0)});
		directed_rows.push_back('{req_of(OP_UNUSED, '1, '1), 1'b1,
			rsp_of(bmhq_pkg::ST_DONE, 1'b0, '0, '0, 0)});
		directed_rows.push_back('{req_of(bmhq_pkg::OP_PUSH, '1, '1), 1'b1,
			rsp_of(bmhq_pkg::ST_DONE, 1'b1, '1, '1, 1)});
		directed_rows.push_back('{req_of(bmhq_pkg::OP_PUSH, '0, '0), 1'b1,
			rsp_of(bmhq_pkg::ST_DONE, 1'b1, '0, '0, 2)});
		directed_rows.push_back('{req_of(bmhq_pkg::OP_PUSH, 16'h1234, '0), 1'b1,
			rsp_of(bmhq_pkg::ST_DONE, 1'b1, '0, '0, 3)});
		directed_rows.push_back('{req_of(bmhq_pkg::OP_PUSH, 16'hAAAA, 32'h0001_8000), 1'b0, '0});
		directed_rows.push_back('{req_of(bmhq_pkg::OP_PUSH, 16'h5555, 32'h0000_0001), 1'b0, '0});
		directed_rows.push_back('{req_of(bmhq_pkg::OP_PUSH, 16'h0F0F, 32'h8000_0000), 1'b0, '0});
		directed_rows.push_back('{req_of(bmhq_pkg::OP_PUSH, 16'h7777, 32'h0000_0001), 1'b0, '0});
		directed_rows.push_back('{req_of(OP_QUERY, 16'hBEEF, 32'hDEAD_BEEF), 1'b0, '0});
		directed_rows.push_back('{req_of(OP_UNUSED, 16'hC3C3, 32'h5A5A_5A5A), 1'b0, '0});
		repeat (6)
			directed_rows.push_back('{req_of(bmhq_pkg::OP_POP, '0, '0), 1'b0, '0});
		directed_rows.push_back('{req_of(bmhq_pkg::OP_POP, '0, '0), 1'b1,
			rsp_of(bmhq_pkg::ST_DONE, 1'b0, '0, '0, 0)});
		directed_rows.push_back('{req_of(bmhq_pkg::OP_POP, '0, '0), 1'b1,
			rsp_of(bmhq_pkg::ST_EMPTY, 1'b0, '0, '0, 0)});
		foreach (directed_rows[i])
			drive_request(directed_rows[i].rq, $urandom_range(0, 5), directed_rows[i].typed,
				directed_rows[i].want);

		for (int blk = 0; blk < 11; blk++) begin
			no_idle = (blk % 3 == 2);
			if (blk == 6) begin
				@(negedge clk);
				start <= 1'b0;
				while (pending_rsp.size() != 0)
					@(posedge clk);
			end
			for (int n = 0; n < 50; n++)
				drive_random(pick_op((blk % 2 == 0) ? 65 : 30));
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (30)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/bmhq_pkg.sv
src/bmhq_ram.sv
src/bmhq_sift.sv
src/binary_min_heap_queue_unit.sv
sim/tb_top.sv
